### sv/fxm_pkg.sv
// ----------------------------------------------------------------------------
// Field-oriented X-drive mixer package
// Shared widths, constants, payload types and the speed shaping function.
// ----------------------------------------------------------------------------
package fxm_pkg;

    // Number formats
    localparam int SPEED_FRAC_BITS = 14;
    localparam int ANGLE_BITS      = 16;
    localparam int SPEED_W         = 16;
    localparam int DZ_W            = 15;
    localparam int TRIG_W          = 18;
    localparam int TRIG_FRAC       = 15;
    localparam int PROD_W          = 34;
    localparam int WHEEL_W         = 37;
    localparam int MV_W            = 15;
    localparam int QUO_BITS        = 14;
    localparam int NUM_W           = 52;
    localparam int LANES           = 4;

    // Queue between the front and the back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;

    // Sine polynomial coefficients
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [14:0] SIN_B = 15'd21024;
    localparam logic [11:0] SIN_C = 12'd2320;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [13:0] FULL_SCALE_MV = 14'd12000;
    localparam logic signed [TRIG_W-1:0] SPEED_ONE = TRIG_W'(1) << SPEED_FRAC_BITS;
    localparam logic [WHEEL_W-1:0] WHEEL_ONE =
        WHEEL_W'(1) << (SPEED_FRAC_BITS + TRIG_FRAC);

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [WHEEL_W-1:0] wheel_t;
    typedef logic        [ANGLE_BITS-1:0] angle_t;

    // Four wheel values handed from the front to the back
    typedef struct packed {
        wheel_t fl;
        wheel_t fr;
        wheel_t bl;
        wheel_t br;
    } mix_t;

    // Speed-side data carried alongside the trig pipeline
    typedef struct packed {
        logic   cmd;
        speed_t x;
        speed_t y;
        speed_t mag;
        speed_t rot;
    } side_t;

    // Sign-extends a speed to the trig width.
    function automatic trig_t sext_speed(speed_t v);
        return {{(TRIG_W - SPEED_W){v[SPEED_W-1]}}, v};
    endfunction

    // Clamps to plus or minus one, then zeroes values inside the deadband.
    function automatic speed_t shape(trig_t v, logic [DZ_W-1:0] dz);
        trig_t             c;
        logic [TRIG_W-1:0] m;
        speed_t            r;
        if (v > SPEED_ONE) begin
            c = SPEED_ONE;
        end else if (v < -SPEED_ONE) begin
            c = -SPEED_ONE;
        end else begin
            c = v;
        end
        m = c[TRIG_W-1] ? TRIG_W'(-c) : TRIG_W'(c);
        if (m <= TRIG_W'(dz)) begin
            r = '0;
        end else begin
            r = c[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/fxm_sin.sv
// ----------------------------------------------------------------------------
// Pipelined sine
// Quadrant fold and a three-term odd polynomial, one product per stage.
// ----------------------------------------------------------------------------
module fxm_sin (
    input  logic           clk,
    input  logic           en,
    input  fxm_pkg::angle_t angle,
    output fxm_pkg::trig_t  sin_val
);
    import fxm_pkg::*;

    logic [1:0]                q;
    logic [ANGLE_BITS-3:0]     r;
    logic [ANGLE_BITS-2:0]     rf;
    logic [ANGLE_BITS+13:0]    z_wide;
    logic [15:0]               z_next;
    logic [31:0]               zz;
    logic [27:0]               m2;
    logic [30:0]               m3;
    logic [31:0]               m4;
    logic [16:0]               t4;

    logic [15:0] z1_reg, z2_1_reg, z_2_reg, z2_2_reg, z_3_reg;
    logic [14:0] t2_reg;
    logic [15:0] t3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    trig_t       out_reg;

    // Fold into the first quadrant and square.
    always_comb
    begin
        q      = angle[ANGLE_BITS-1:ANGLE_BITS-2];
        r      = angle[ANGLE_BITS-3:0];
        rf     = q[0] ? (QUARTER_TURN[ANGLE_BITS-2:0] - {1'b0, r}) : {1'b0, r};
        z_wide = {rf, 15'b0} >> (ANGLE_BITS - 2);
        z_next = z_wide[15:0];
        zz     = z_next * z_next;
    end

    // Polynomial terms, one product each.
    always_comb
    begin
        m2 = SIN_C * z2_1_reg;
        m3 = t2_reg * z2_2_reg;
        m4 = t3_reg * z_3_reg;
        t4 = m4[31:15];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg   <= z_next;
            z2_1_reg <= zz[30:15];
            neg1_reg <= q[1];
            t2_reg   <= SIN_B - m2[27:15];
            z_2_reg  <= z1_reg;
            z2_2_reg <= z2_1_reg;
            neg2_reg <= neg1_reg;
            t3_reg   <= SIN_A - {1'b0, m3[29:15]};
            z_3_reg  <= z_2_reg;
            neg3_reg <= neg2_reg;
            out_reg  <= neg3_reg ? -trig_t'({1'b0, t4}) : trig_t'({1'b0, t4});
        end
    end

    assign sin_val = out_reg;

endmodule

### sv/fxm_front.sv
// ----------------------------------------------------------------------------
// Mixer front end
// Accepts commands, shapes speeds, resolves polar commands and mixes wheels.
// ----------------------------------------------------------------------------
module fxm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [fxm_pkg::DZ_W-1:0]   dz,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  fxm_pkg::speed_t            x_speed,
    input  fxm_pkg::speed_t            y_speed,
    input  fxm_pkg::speed_t            magnitude,
    input  fxm_pkg::angle_t            direction,
    input  fxm_pkg::speed_t            rotation,
    input  fxm_pkg::angle_t            heading,
    output logic                       push,
    input  logic                       full,
    output fxm_pkg::mix_t              mix
);
    import fxm_pkg::*;

    logic en;
    logic accept;

    // Stage 0: captured transaction
    logic   v0_reg;
    logic   cmd0_reg;
    speed_t x0_reg, y0_reg, mag0_reg, rot0_reg;
    angle_t dir0_reg, head0_reg;

    // Stages 1 to 4: shaped speeds beside the trig pipeline
    logic  v_reg    [4];
    side_t side_reg [4];
    side_t side_next;

    // Trig results, aligned with stage 4
    trig_t sin_d, cos_d, sin_h, cos_h;

    // Stage 5: cartesian components
    logic  v5_reg;
    trig_t x5_reg, y5_reg;
    speed_t rot5_reg;
    trig_t sh5_reg, ch5_reg;
    prod_t pf, pr;
    prod_t pf_b, pr_b;
    prod_t pf_s, pr_s;
    trig_t x5_next, y5_next;

    // Stage 6: rotated products
    logic  v6_reg;
    prod_t p1_reg, p2_reg, p3_reg, p4_reg;
    wheel_t zq_reg;
    speed_t xs6, ys6, zr6;
    wheel_t fwd, right;

    // Flow control: stage 6 waits only on a full queue.
    assign en       = !(v6_reg && full);
    assign in_stall = !en;
    assign accept   = in_valid && en;
    assign push     = v6_reg && !full;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= accept;
            v_reg[0] <= v0_reg;
            for (int i = 1; i < 4; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            v5_reg <= v_reg[3];
            v6_reg <= v5_reg;
        end
    end

    // Capture the transaction.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd0_reg  <= command;
            x0_reg    <= x_speed;
            y0_reg    <= y_speed;
            mag0_reg  <= magnitude;
            dir0_reg  <= direction;
            rot0_reg  <= rotation;
            head0_reg <= heading;
        end
    end

    // Sine and cosine of the travel direction and the heading.
    fxm_sin u_sin_d (.clk(clk), .en(en), .angle(dir0_reg), .sin_val(sin_d));
    fxm_sin u_cos_d (.clk(clk), .en(en), .angle(dir0_reg + QUARTER_TURN), .sin_val(cos_d));
    fxm_sin u_sin_h (.clk(clk), .en(en), .angle(head0_reg), .sin_val(sin_h));
    fxm_sin u_cos_h (.clk(clk), .en(en), .angle(head0_reg + QUARTER_TURN), .sin_val(cos_h));

    // Shape every speed on entry; the cartesian components are shaped again before the rotation.
    always_comb
    begin
        side_next.cmd = cmd0_reg;
        side_next.x   = shape(sext_speed(x0_reg), dz);
        side_next.y   = shape(sext_speed(y0_reg), dz);
        side_next.mag = shape(sext_speed(mag0_reg), dz);
        side_next.rot = shape(sext_speed(rot0_reg), dz);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < 4; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Polar to cartesian, truncating toward zero.
    always_comb
    begin
        pf      = side_reg[3].mag * sin_d;
        pr      = side_reg[3].mag * cos_d;
        pf_b    = pf + (pf[PROD_W-1] ? prod_t'(32767) : prod_t'(0));
        pr_b    = pr + (pr[PROD_W-1] ? prod_t'(32767) : prod_t'(0));
        pf_s    = pf_b >>> TRIG_FRAC;
        pr_s    = pr_b >>> TRIG_FRAC;
        x5_next = side_reg[3].cmd ? pf_s[TRIG_W-1:0] : sext_speed(side_reg[3].x);
        y5_next = side_reg[3].cmd ? pr_s[TRIG_W-1:0] : sext_speed(side_reg[3].y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x5_reg   <= x5_next;
            y5_reg   <= y5_next;
            rot5_reg <= side_reg[3].rot;
            sh5_reg  <= sin_h;
            ch5_reg  <= cos_h;
        end
    end

    // Shape the components and rotate by the heading.
    always_comb
    begin
        xs6 = shape(x5_reg, dz);
        ys6 = -shape(y5_reg, dz);
        zr6 = rot5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= xs6 * ch5_reg;
            p2_reg <= ys6 * sh5_reg;
            p3_reg <= xs6 * sh5_reg;
            p4_reg <= ys6 * ch5_reg;
            zq_reg <= wheel_t'(zr6) <<< TRIG_FRAC;
        end
    end

    // Wheel mix.
    always_comb
    begin
        fwd     = wheel_t'(p1_reg) - wheel_t'(p2_reg);
        right   = wheel_t'(p3_reg) + wheel_t'(p4_reg);
        mix.fl  = fwd - right + zq_reg;
        mix.fr  = fwd + right - zq_reg;
        mix.bl  = fwd + right + zq_reg;
        mix.br  = fwd - right - zq_reg;
    end

endmodule

### sv/fxm_fifo.sv
// ----------------------------------------------------------------------------
// Mixer queue
// Short first-in first-out queue of wheel values between front and back.
// ----------------------------------------------------------------------------
module fxm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fxm_pkg::mix_t data_in,
    output logic          full,
    input  logic          pop,
    output logic          avail,
    output fxm_pkg::mix_t data_out
);
    import fxm_pkg::*;

    mix_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign avail    = (count_reg != '0);
    assign data_out = mem[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= data_in;
        end
    end

endmodule

### sv/fxm_back.sv
// ----------------------------------------------------------------------------
// Mixer back end
// Finds the largest wheel, then divides each scaled wheel by it bit by bit.
// ----------------------------------------------------------------------------
module fxm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            avail,
    input  fxm_pkg::mix_t                   mix,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [fxm_pkg::MV_W-1:0] front_left_mv,
    output logic signed [fxm_pkg::MV_W-1:0] front_right_mv,
    output logic signed [fxm_pkg::MV_W-1:0] back_left_mv,
    output logic signed [fxm_pkg::MV_W-1:0] back_right_mv
);
    import fxm_pkg::*;

    logic be;

    wheel_t            w [LANES];
    logic [WHEEL_W-1:0] abs_next [LANES];

    // Stage B0: magnitudes and signs
    logic               vb0_reg;
    logic [WHEEL_W-1:0] abs_reg [LANES];
    logic               neg0_reg [LANES];

    // Stage B1: divisor and scaled numerators
    logic               vb1_reg;
    logic [WHEEL_W-1:0] den_reg;
    logic [NUM_W-1:0]   num_reg [LANES];
    logic               neg1_reg [LANES];
    logic [WHEEL_W-1:0] m01, m23, m_all, den_next;

    // Divider stages
    logic               dv_reg   [QUO_BITS];
    logic [WHEEL_W-1:0] dden_reg [QUO_BITS];
    logic [NUM_W-1:0]   rem_reg  [QUO_BITS][LANES];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS][LANES];
    logic               sgn_reg  [QUO_BITS][LANES];

    logic [MV_W-1:0] mv [LANES];

    // The back end holds only when a finished result is not taken.
    assign be        = !(dv_reg[QUO_BITS-1] && out_stall);
    assign pop       = be && avail;
    assign out_valid = dv_reg[QUO_BITS-1];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb0_reg <= 1'b0;
            vb1_reg <= 1'b0;
            for (int j = 0; j < QUO_BITS; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
        end
        else if (be)
        begin
            vb0_reg   <= pop;
            vb1_reg   <= vb0_reg;
            dv_reg[0] <= vb1_reg;
            for (int j = 1; j < QUO_BITS; j++)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end
    end

    // Magnitudes of the queued wheels.
    always_comb
    begin
        w[0] = mix.fl;
        w[1] = mix.fr;
        w[2] = mix.bl;
        w[3] = mix.br;
        for (int i = 0; i < LANES; i++)
        begin
            abs_next[i] = w[i][WHEEL_W-1] ? WHEEL_W'(-w[i]) : WHEEL_W'(w[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                abs_reg[i]  <= abs_next[i];
                neg0_reg[i] <= w[i][WHEEL_W-1];
            end
        end
    end

    // Largest magnitude, floored at one.
    always_comb
    begin
        m01      = (abs_reg[0] > abs_reg[1]) ? abs_reg[0] : abs_reg[1];
        m23      = (abs_reg[2] > abs_reg[3]) ? abs_reg[2] : abs_reg[3];
        m_all    = (m01 > m23) ? m01 : m23;
        den_next = (m_all > WHEEL_ONE) ? m_all : WHEEL_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            den_reg <= den_next;
            for (int i = 0; i < LANES; i++)
            begin
                num_reg[i]  <= NUM_W'(abs_reg[i]) * NUM_W'(FULL_SCALE_MV);
                neg1_reg[i] <= neg0_reg[i];
            end
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        logic [WHEEL_W-1:0]  den_in;
        logic [NUM_W-1:0]    rem_in   [LANES];
        logic [QUO_BITS-1:0] quo_in   [LANES];
        logic                sgn_in   [LANES];
        logic [NUM_W-1:0]    shifted;
        logic [NUM_W-1:0]    rem_next [LANES];
        logic [QUO_BITS-1:0] quo_next [LANES];

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (j == 0)
                begin
                    rem_in[i] = num_reg[i];
                    quo_in[i] = '0;
                    sgn_in[i] = neg1_reg[i];
                end
                else
                begin
                    rem_in[i] = rem_reg[(j == 0) ? 0 : j-1][i];
                    quo_in[i] = quo_reg[(j == 0) ? 0 : j-1][i];
                    sgn_in[i] = sgn_reg[(j == 0) ? 0 : j-1][i];
                end
            end
            den_in  = (j == 0) ? den_reg : dden_reg[(j == 0) ? 0 : j-1];
            shifted = NUM_W'(den_in) << (QUO_BITS - 1 - j);
            for (int i = 0; i < LANES; i++)
            begin
                if (rem_in[i] >= shifted)
                begin
                    rem_next[i] = rem_in[i] - shifted;
                    quo_next[i] = quo_in[i] | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = quo_in[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                dden_reg[j] <= den_in;
                for (int i = 0; i < LANES; i++)
                begin
                    rem_reg[j][i] <= rem_next[i];
                    quo_reg[j][i] <= quo_next[i];
                    sgn_reg[j][i] <= sgn_in[i];
                end
            end
        end
    end

    // Apply the signs to the quotients.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mv[i] = sgn_reg[QUO_BITS-1][i] ? -MV_W'(quo_reg[QUO_BITS-1][i])
                                           :  MV_W'(quo_reg[QUO_BITS-1][i]);
        end
    end

    assign front_left_mv  = mv[0];
    assign front_right_mv = mv[1];
    assign back_left_mv   = mv[2];
    assign back_right_mv  = mv[3];

endmodule

### sv/field_oriented_x_drive_mixer.sv
// ----------------------------------------------------------------------------
// Field-oriented X-drive mixer
// Turns a cartesian or polar drive command into four motor voltages.
// ----------------------------------------------------------------------------
// Channel    Handshake                    Payload
// input      in_valid / in_stall          command, speeds, direction, heading
// output     out_valid / out_stall        four wheel voltages in mV
// config     dead_zone_valid / _ready     dead_zone
//
// One transaction per cycle is accepted and delivered in steady state while out_stall is low.
// The path runs through seven front stages (set by the four-stage sine
// pipeline), the queue, two normalize stages and fourteen
// divider stages, one quotient bit each.
// Reset clears all valid bits, the queue pointers and dead_zone.
// out_stall holds only the back end; the front keeps filling the four-entry
// queue and raises in_stall once it is full and stage 6 holds a result.
// ----------------------------------------------------------------------------
module field_oriented_x_drive_mixer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            dead_zone_valid,
    output logic                            dead_zone_ready,
    input  logic [fxm_pkg::DZ_W-1:0]        dead_zone,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  fxm_pkg::speed_t                 x_speed,
    input  fxm_pkg::speed_t                 y_speed,
    input  fxm_pkg::speed_t                 magnitude,
    input  fxm_pkg::angle_t                 direction,
    input  fxm_pkg::speed_t                 rotation,
    input  fxm_pkg::angle_t                 heading,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [fxm_pkg::MV_W-1:0] front_left_mv,
    output logic signed [fxm_pkg::MV_W-1:0] front_right_mv,
    output logic signed [fxm_pkg::MV_W-1:0] back_left_mv,
    output logic signed [fxm_pkg::MV_W-1:0] back_right_mv
);
    import fxm_pkg::*;

    logic [DZ_W-1:0] dead_zone_reg;
    logic            push, full, pop, avail;
    mix_t            mix_in, mix_out;

    // Deadband register
    assign dead_zone_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= '0;
        end
        else if (dead_zone_valid && dead_zone_ready)
        begin
            dead_zone_reg <= dead_zone;
        end
    end

    // Front end
    fxm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dz        (dead_zone_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .x_speed   (x_speed),
        .y_speed   (y_speed),
        .magnitude (magnitude),
        .direction (direction),
        .rotation  (rotation),
        .heading   (heading),
        .push      (push),
        .full      (full),
        .mix       (mix_in)
    );

    // Queue
    fxm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (mix_in),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .data_out (mix_out)
    );

    // Back end
    fxm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .avail          (avail),
        .mix            (mix_out),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .front_left_mv  (front_left_mv),
        .front_right_mv (front_right_mv),
        .back_left_mv   (back_left_mv),
        .back_right_mv  (back_right_mv)
    );

endmodule
